// ===== rtl/thick_line_stepper_top_assert.svh =====
// Assertion helpers for the thick line stepper.
`ifndef THICK_LINE_STEPPER_TOP_ASSERT_SVH
`define THICK_LINE_STEPPER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TLS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/tls_pkg.sv =====
`default_nettype none
package tls_pkg;

  localparam int COORD_BITS  = 12;
  localparam int PEN_BITS    = 4;
  localparam int INK_BITS    = 32;
  localparam int POS_BITS    = 11;
  localparam int ERR_BITS    = COORD_BITS + 3;
  localparam int CLIP_BITS   = COORD_BITS + 3;
  localparam int QDEPTH      = 4;
  localparam int QPTR_BITS   = $clog2(QDEPTH);
  localparam int QCNT_BITS   = $clog2(QDEPTH + 1);
  localparam int IN_FIELD_W  = 4 * COORD_BITS + PEN_BITS + INK_BITS;
  localparam int IN_TDATA_W  = ((IN_FIELD_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W = 2 * POS_BITS + 2 * PEN_BITS + INK_BITS;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } cmd_kind_t;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // Decoded item with the line setup already worked out for loads.
  typedef struct packed {
    cmd_kind_t             kind;
    coord_t                x0;
    coord_t                y0;
    coord_t                x1;
    coord_t                y1;
    logic [COORD_BITS-1:0] span_x;
    logic [COORD_BITS-1:0] span_y;
    logic                  dir_x_neg;
    logic                  dir_y_neg;
    logic [PEN_BITS-1:0]   pen;
    logic [INK_BITS-1:0]   ink;
  } line_cmd_t;

  // One stamp center handed from the walker to the clipper.
  typedef struct packed {
    coord_t              cur_x;
    coord_t              cur_y;
    logic [PEN_BITS-1:0] pen;
    logic [INK_BITS-1:0] ink;
    logic                last;
  } stamp_pt_t;

endpackage
`default_nettype wire

// ===== rtl/thick_line_stepper_top.sv =====
// Thick line stepper: one input word per clock is accepted while the queue is not full. A
// load word (tuser = 0) sets up a line and returns nothing; each step word (tuser = 1) on
// an active line returns one clipped square stamp by way of the command queue, the
// walker's point register and the clipper's output register, and a step word with no
// active line is dropped. The walker updates its error term with two compares and up to
// two adds per stamp, which sets the one-word-per-cycle rate. A four-entry command queue
// sits between the input decoder and the walker; the stamp clipper holds its result in an
// output register, so the input keeps flowing while a stamp waits until the queue fills.
`default_nettype none
`include "thick_line_stepper_top_assert.svh"
module thick_line_stepper_top import tls_pkg::*; #(
  parameter int CANVAS_WIDTH  = 1280,
  parameter int CANVAS_HEIGHT = 800
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // start_x, start_y, end_x, end_y, pen_size, ink, zero pad
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // cmd
  input  wire logic                   in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // rect_left, rect_top, rect_width, rect_height, pixel_ink, zero pad
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // rect_empty
  output logic                        out_tuser,
  output logic                        out_tlast
);

  logic                q_full, q_push, q_pop, q_valid;
  line_cmd_t           q_wdata, q_rdata;
  logic                pt_valid, pt_ready;
  stamp_pt_t           pt_data;
  logic [POS_BITS-1:0] rect_left, rect_top;
  logic [PEN_BITS-1:0] rect_width, rect_height;
  logic [INK_BITS-1:0] pixel_ink;

  tls_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  tls_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_valid),
    .rdata  (q_rdata)
  );

  tls_walker u_walker (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_item   (q_rdata),
    .q_pop    (q_pop),
    .pt_valid (pt_valid),
    .pt_ready (pt_ready),
    .pt_data  (pt_data)
  );

  tls_clip #(
    .CANVAS_WIDTH  (CANVAS_WIDTH),
    .CANVAS_HEIGHT (CANVAS_HEIGHT)
  ) u_clip (
    .clk         (clk),
    .rst_n       (rst_n),
    .pt_valid    (pt_valid),
    .pt_ready    (pt_ready),
    .pt_data     (pt_data),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .rect_left   (rect_left),
    .rect_top    (rect_top),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .rect_empty  (out_tuser),
    .pixel_ink   (pixel_ink),
    .last        (out_tlast)
  );

  assign out_tdata = {{(OUT_TDATA_W-OUT_FIELD_W){1'b0}}, pixel_ink, rect_height, rect_width,
                      rect_top, rect_left};

  `TLS_ASSERT_NOW(a_empty_zero, out_tvalid && out_tuser, (rect_left == '0) && (rect_top == '0) && (rect_width == '0) && (rect_height == '0), "empty stamp carries a nonzero rectangle")
  `TLS_ASSERT_NOW(a_full_nonzero, out_tvalid && !out_tuser, (rect_width != '0) && (rect_height != '0), "drawable stamp has a zero side")
  `TLS_ASSERT_NOW(a_on_canvas, out_tvalid && !out_tuser, ({1'b0, rect_left} + rect_width <= (POS_BITS+1)'(CANVAS_WIDTH)) && ({1'b0, rect_top} + rect_height <= (POS_BITS+1)'(CANVAS_HEIGHT)), "stamp reaches past the canvas")
  `TLS_ASSERT_NEXT(a_push_lands, q_push && !q_pop, q_valid, "queued word not visible to the walker")

endmodule
`default_nettype wire

// ===== rtl/tls_front.sv =====
`default_nettype none
module tls_front import tls_pkg::*; (
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_TDATA_W-1:0] in_tdata,
  input  wire logic                  in_tuser,
  input  wire logic                  q_full,
  output logic                       q_push,
  output line_cmd_t                  q_wdata
);

  coord_t                  x0, y0, x1, y1;
  logic signed [COORD_BITS:0] dx, dy, adx, ady;

  assign x0 = in_tdata[COORD_BITS-1:0];
  assign y0 = in_tdata[2*COORD_BITS-1:COORD_BITS];
  assign x1 = in_tdata[3*COORD_BITS-1:2*COORD_BITS];
  assign y1 = in_tdata[4*COORD_BITS-1:3*COORD_BITS];

  always_comb begin
    dx  = {x1[COORD_BITS-1], x1} - {x0[COORD_BITS-1], x0};
    dy  = {y1[COORD_BITS-1], y1} - {y0[COORD_BITS-1], y0};
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_wdata.kind      = cmd_kind_t'(in_tuser);
    q_wdata.x0        = x0;
    q_wdata.y0        = y0;
    q_wdata.x1        = x1;
    q_wdata.y1        = y1;
    q_wdata.span_x    = adx[COORD_BITS-1:0];
    q_wdata.span_y    = ady[COORD_BITS-1:0];
    // A line that does not move on an axis still counts as walking backward.
    q_wdata.dir_x_neg = (dx <= 0);
    q_wdata.dir_y_neg = (dy <= 0);
    q_wdata.pen       = in_tdata[4*COORD_BITS+PEN_BITS-1:4*COORD_BITS];
    q_wdata.ink       = in_tdata[IN_FIELD_W-1:4*COORD_BITS+PEN_BITS];
  end

endmodule
`default_nettype wire

// ===== rtl/tls_queue.sv =====
`default_nettype none
module tls_queue import tls_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  line_cmd_t      wdata,
  output logic           full,
  input  wire logic      pop,
  output logic           rvalid,
  output line_cmd_t      rdata
);

  line_cmd_t              mem_r [QDEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_BITS-1:0]   count_r;
  logic                   do_pop;

  assign full   = (count_r == QCNT_BITS'(QDEPTH));
  assign rvalid = (count_r != '0);
  assign rdata  = mem_r[rd_ptr_r];
  assign do_pop = pop && rvalid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tls_walker.sv =====
`default_nettype none
module tls_walker import tls_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_valid,
  input  line_cmd_t q_item,
  output logic      q_pop,
  output logic      pt_valid,
  input  wire logic pt_ready,
  output stamp_pt_t pt_data
);

  logic                  busy_r;
  coord_t                cur_x_r, cur_y_r, tgt_x_r, tgt_y_r;
  logic [COORD_BITS-1:0] span_x_r, span_y_r;
  logic                  dir_x_neg_r, dir_y_neg_r;
  logic signed [ERR_BITS-1:0] err_r;
  logic [PEN_BITS-1:0]   size_r;
  logic [INK_BITS-1:0]   ink_r;
  logic                  pt_valid_r;
  stamp_pt_t             pt_r;

  logic                  is_load, emit, fin, step_x, step_y;
  logic signed [ERR_BITS:0] e2, sx, sy, err_sum, load_err;

  assign is_load = (q_item.kind == CMD_LOAD);
  // Loads and steps on an idle walker make no point, so they never wait on the output.
  assign q_pop   = q_valid && (is_load || !busy_r || !pt_valid_r || pt_ready);
  assign emit    = q_pop && !is_load && busy_r;
  assign fin     = (cur_x_r == tgt_x_r) && (cur_y_r == tgt_y_r);

  always_comb begin
    e2       = {err_r, 1'b0};
    sx       = {{(ERR_BITS+1-COORD_BITS){1'b0}}, span_x_r};
    sy       = {{(ERR_BITS+1-COORD_BITS){1'b0}}, span_y_r};
    step_x   = (e2 >= -sy);
    step_y   = (e2 <= sx);
    err_sum  = {err_r[ERR_BITS-1], err_r};
    if (step_x) begin
      err_sum = err_sum - sy;
    end
    if (step_y) begin
      err_sum = err_sum + sx;
    end
    load_err = {{(ERR_BITS+1-COORD_BITS){1'b0}}, q_item.span_x}
             - {{(ERR_BITS+1-COORD_BITS){1'b0}}, q_item.span_y};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      tgt_x_r     <= '0;
      tgt_y_r     <= '0;
      span_x_r    <= '0;
      span_y_r    <= '0;
      dir_x_neg_r <= 1'b0;
      dir_y_neg_r <= 1'b0;
      err_r       <= '0;
      size_r      <= PEN_BITS'(1);
      ink_r       <= '0;
      pt_valid_r  <= 1'b0;
    end else begin
      if (q_pop && is_load) begin
        busy_r      <= 1'b1;
        cur_x_r     <= q_item.x0;
        cur_y_r     <= q_item.y0;
        tgt_x_r     <= q_item.x1;
        tgt_y_r     <= q_item.y1;
        span_x_r    <= q_item.span_x;
        span_y_r    <= q_item.span_y;
        dir_x_neg_r <= q_item.dir_x_neg;
        dir_y_neg_r <= q_item.dir_y_neg;
        err_r       <= load_err[ERR_BITS-1:0];
        size_r      <= q_item.pen;
        ink_r       <= q_item.ink;
      end else if (emit) begin
        if (fin) begin
          busy_r <= 1'b0;
        end else begin
          err_r <= err_sum[ERR_BITS-1:0];
          if (step_x) begin
            cur_x_r <= dir_x_neg_r ? cur_x_r - 1'b1 : cur_x_r + 1'b1;
          end
          if (step_y) begin
            cur_y_r <= dir_y_neg_r ? cur_y_r - 1'b1 : cur_y_r + 1'b1;
          end
        end
      end
      if (emit) begin
        pt_valid_r <= 1'b1;
      end else if (pt_ready) begin
        pt_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pt_r.cur_x <= cur_x_r;
      pt_r.cur_y <= cur_y_r;
      pt_r.pen   <= size_r;
      pt_r.ink   <= ink_r;
      pt_r.last  <= fin;
    end
  end

  assign pt_valid = pt_valid_r;
  assign pt_data  = pt_r;

endmodule
`default_nettype wire

// ===== rtl/tls_clip.sv =====
`default_nettype none
module tls_clip import tls_pkg::*; #(
  parameter int CANVAS_WIDTH  = 1280,
  parameter int CANVAS_HEIGHT = 800
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                pt_valid,
  output logic                     pt_ready,
  input  stamp_pt_t                pt_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [POS_BITS-1:0]      rect_left,
  output logic [POS_BITS-1:0]      rect_top,
  output logic [PEN_BITS-1:0]      rect_width,
  output logic [PEN_BITS-1:0]      rect_height,
  output logic                     rect_empty,
  output logic [INK_BITS-1:0]      pixel_ink,
  output logic                     last
);

  typedef logic signed [CLIP_BITS-1:0] clip_val_t;

  typedef struct packed {
    clip_val_t org;
    clip_val_t len;
  } clip_res_t;

  // Pull the origin onto the canvas, then cut the far edge at the limit.
  function automatic clip_res_t clip_axis(input clip_val_t org, input clip_val_t len,
                                          input clip_val_t lim);
    clip_res_t r;
    r.org = org;
    r.len = len;
    if (r.org < 0) begin
      r.len = r.len + r.org;
      r.org = '0;
    end
    if (r.org + r.len > lim) begin
      r.len = lim - r.org;
    end
    return r;
  endfunction

  localparam clip_val_t LIM_X = CLIP_BITS'(CANVAS_WIDTH);
  localparam clip_val_t LIM_Y = CLIP_BITS'(CANVAS_HEIGHT);

  clip_val_t   half, size, org_x, org_y;
  clip_res_t   cx, cy;
  logic        empty;
  logic        take;

  logic                out_valid_r;
  logic [POS_BITS-1:0] left_r, top_r;
  logic [PEN_BITS-1:0] width_r, height_r;
  logic                empty_r, last_r;
  logic [INK_BITS-1:0] ink_r;

  always_comb begin
    half  = CLIP_BITS'(pt_data.pen >> 1);
    size  = CLIP_BITS'(pt_data.pen);
    org_x = {{(CLIP_BITS-COORD_BITS){pt_data.cur_x[COORD_BITS-1]}}, pt_data.cur_x} - half;
    org_y = {{(CLIP_BITS-COORD_BITS){pt_data.cur_y[COORD_BITS-1]}}, pt_data.cur_y} - half;
    cx    = clip_axis(org_x, size, LIM_X);
    cy    = clip_axis(org_y, size, LIM_Y);
    empty = (cx.len <= 0) || (cy.len <= 0);
  end

  assign pt_ready = !out_valid_r || out_ready;
  assign take     = pt_valid && pt_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      left_r   <= empty ? '0 : cx.org[POS_BITS-1:0];
      top_r    <= empty ? '0 : cy.org[POS_BITS-1:0];
      width_r  <= empty ? '0 : cx.len[PEN_BITS-1:0];
      height_r <= empty ? '0 : cy.len[PEN_BITS-1:0];
      empty_r  <= empty;
      ink_r    <= pt_data.ink;
      last_r   <= pt_data.last;
    end
  end

  assign out_valid   = out_valid_r;
  assign rect_left   = left_r;
  assign rect_top    = top_r;
  assign rect_width  = width_r;
  assign rect_height = height_r;
  assign rect_empty  = empty_r;
  assign pixel_ink   = ink_r;
  assign last        = last_r;

endmodule
`default_nettype wire

// ===== bench/thick_line_stepper_top_test.sv =====
`timescale 1ns / 100ps
module thick_line_stepper_top_test;
  import tls_pkg::*;

  localparam int PERIOD     = 10;
  localparam int CANVAS_W   = 1280;
  localparam int CANVAS_H   = 800;
  localparam int RAND_WORDS = 1500;
  localparam int QUIET_MAX  = 5000;
  localparam int HOLD_LEN   = 400;

  typedef struct packed {
    logic [POS_BITS-1:0] left_col;
    logic [POS_BITS-1:0] top_row;
    logic [PEN_BITS-1:0] wid;
    logic [PEN_BITS-1:0] hgt;
    logic                empty;
    logic [INK_BITS-1:0] ink;
    logic                fin;
  } stamp_t;

  typedef struct packed {
    cmd_kind_t           kind;
    int                  sx;
    int                  sy;
    int                  ex;
    int                  ey;
    int                  pen;
    logic [INK_BITS-1:0] ink;
    logic                typed;
    stamp_t              want;
  } stim_row_t;

  localparam stamp_t NO_STAMP = '0;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;

  // Walker state kept by the predictor.
  int                  pen_x, pen_y, goal_x, goal_y;
  int                  run_x, rise_neg, slope_err;
  bit                  back_x, back_y;
  int                  side;
  logic [INK_BITS-1:0] line_color;
  bit                  drawing;

  stamp_t    stamp_q[$];
  stamp_t    due_stamp;
  stim_row_t dir_rows[$];
  int        mismatches = 0;
  int        words_sent = 0;
  int        quiet_cycles = 0;
  int        send_gap_pct = 10;
  int        stall_pct = 10;
  bit        hold_req = 1'b0;

  thick_line_stepper_top #(
    .CANVAS_WIDTH  (CANVAS_W),
    .CANVAS_HEIGHT (CANVAS_H)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #(PERIOD / 2) clk = ~clk;

  function automatic stamp_t mk_stamp(int l, int t, int w, int h, bit e,
                                      logic [INK_BITS-1:0] ink, bit fin);
    stamp_t s;
    s.left_col = l[POS_BITS-1:0];
    s.top_row  = t[POS_BITS-1:0];
    s.wid      = w[PEN_BITS-1:0];
    s.hgt      = h[PEN_BITS-1:0];
    s.empty    = e;
    s.ink      = ink;
    s.fin      = fin;
    return s;
  endfunction

  function automatic logic [IN_TDATA_W-1:0] line_word(int sx, int sy, int ex, int ey,
                                                      int pen, logic [INK_BITS-1:0] ink);
    logic [IN_TDATA_W-1:0] d;
    d = '0;
    d[0 +: COORD_BITS]                  = sx[COORD_BITS-1:0];
    d[COORD_BITS +: COORD_BITS]         = sy[COORD_BITS-1:0];
    d[2*COORD_BITS +: COORD_BITS]       = ex[COORD_BITS-1:0];
    d[3*COORD_BITS +: COORD_BITS]       = ey[COORD_BITS-1:0];
    d[4*COORD_BITS +: PEN_BITS]         = pen[PEN_BITS-1:0];
    d[4*COORD_BITS+PEN_BITS +: INK_BITS] = ink;
    return d;
  endfunction

  function automatic logic [IN_TDATA_W-1:0] rand_word();
    logic [IN_TDATA_W-1:0] d;
    d = IN_TDATA_W'({$urandom, $urandom, $urandom});
    d[IN_TDATA_W-1:IN_FIELD_W] = '0;
    return d;
  endfunction

  // Clips one axis of the stamp against [0, lim) and returns the length left.
  function automatic int clip_span(inout int org, input int len, input int lim);
    if (org < 0) begin
      len = len + org;
      org = 0;
    end
    if (org + len > lim) len = lim - org;
    return len;
  endfunction

  // Updates the walker for one word and returns 1 when a stamp comes out of it.
  function automatic bit walk_item(input cmd_kind_t kind, input logic [IN_TDATA_W-1:0] d,
                                   output stamp_t s);
    coord_t c0, c1, c2, c3;
    int     half, x, y, w, h, e2;
    bit     empty, fin;
    s = '0;
    if (kind == CMD_LOAD) begin
      c0 = d[0 +: COORD_BITS];
      c1 = d[COORD_BITS +: COORD_BITS];
      c2 = d[2*COORD_BITS +: COORD_BITS];
      c3 = d[3*COORD_BITS +: COORD_BITS];
      pen_x = c0;
      pen_y = c1;
      goal_x = c2;
      goal_y = c3;
      run_x = (goal_x > pen_x) ? goal_x - pen_x : pen_x - goal_x;
      rise_neg = (goal_y > pen_y) ? pen_y - goal_y : goal_y - pen_y;
      back_x = !(pen_x < goal_x);
      back_y = !(pen_y < goal_y);
      slope_err = run_x + rise_neg;
      side = d[4*COORD_BITS +: PEN_BITS];
      line_color = d[4*COORD_BITS+PEN_BITS +: INK_BITS];
      drawing = 1'b1;
      return 1'b0;
    end
    if (!drawing) return 1'b0;

    half = side / 2;
    x = pen_x - half;
    y = pen_y - half;
    w = clip_span(x, side, CANVAS_W);
    h = clip_span(y, side, CANVAS_H);
    empty = (w <= 0) || (h <= 0);
    fin = (pen_x == goal_x) && (pen_y == goal_y);
    if (empty) s = mk_stamp(0, 0, 0, 0, 1'b1, line_color, fin);
    else s = mk_stamp(x, y, w, h, 1'b0, line_color, fin);

    if (fin) begin
      drawing = 1'b0;
    end else begin
      // Both tests use the error term from before either update.
      e2 = slope_err * 2;
      if (e2 >= rise_neg) begin
        slope_err += rise_neg;
        pen_x += back_x ? -1 : 1;
      end
      if (e2 <= run_x) begin
        slope_err += run_x;
        pen_y += back_y ? -1 : 1;
      end
    end
    return 1'b1;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic int pick_coord(int lim);
    case ($urandom_range(0, 2))
      0: return int'($urandom_range(0, 40)) - 20;
      1: return lim + int'($urandom_range(0, 40)) - 20;
      default: return int'($urandom_range(0, 4095)) - 2048;
    endcase
  endfunction

  function automatic int clamp_coord(int v);
    if (v > 2047) return 2047;
    if (v < -2048) return -2048;
    return v;
  endfunction

  task automatic push_word(input cmd_kind_t kind, input logic [IN_TDATA_W-1:0] d,
                           input bit typed, input stamp_t want);
    stamp_t s;
    bit     got;
    if ($urandom_range(0, 99) < send_gap_pct) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = kind;
    in_tdata  = d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    got = walk_item(kind, d, s);
    if (typed) stamp_q.push_back(want);
    else if (got) stamp_q.push_back(s);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic settle_input();
    in_tvalid = 1'b0;
    while (stamp_q.size() != 0) @(negedge clk);
  endtask

  // A load followed by the steps that walk the line, now and then cut short
  // by the next load or padded with steps that find no line.
  task automatic draw_line();
    int sx, sy, ex, ey, reach, pen, steps, ax, ay;
    reach = ($urandom_range(0, 19) == 0) ? 150 : 12;
    sx = pick_coord(CANVAS_W);
    sy = pick_coord(CANVAS_H);
    ex = clamp_coord(sx + int'($urandom_range(0, 2 * reach)) - reach);
    ey = clamp_coord(sy + int'($urandom_range(0, 2 * reach)) - reach);
    pen = ($urandom_range(0, 19) == 0) ? 0 : int'($urandom_range(1, 15));
    push_word(CMD_LOAD, line_word(sx, sy, ex, ey, pen, $urandom), 1'b0, NO_STAMP);
    ax = (ex > sx) ? ex - sx : sx - ex;
    ay = (ey > sy) ? ey - sy : sy - ey;
    steps = ((ax > ay) ? ax : ay) + 1;
    if ($urandom_range(0, 9) == 0) steps = $urandom_range(0, steps - 1);
    else if ($urandom_range(0, 9) == 0) steps += $urandom_range(1, 3);
    repeat (steps) push_word(CMD_STEP, rand_word(), 1'b0, NO_STAMP);
  endtask

  // Receiver side: random stalls, plus one long hold when asked for.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready = 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
        hold_req = 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
      out_tready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (stamp_q.size() == 0) begin
        $error("stamp word with none expected: tdata %h", out_tdata);
        mismatches++;
      end else begin
        due_stamp = stamp_q.pop_front();
        check_field("rect_left", due_stamp.left_col, out_tdata[0 +: POS_BITS]);
        check_field("rect_top", due_stamp.top_row, out_tdata[POS_BITS +: POS_BITS]);
        check_field("rect_width", due_stamp.wid, out_tdata[2*POS_BITS +: PEN_BITS]);
        check_field("rect_height", due_stamp.hgt,
                    out_tdata[2*POS_BITS+PEN_BITS +: PEN_BITS]);
        check_field("rect_empty", due_stamp.empty, out_tuser);
        check_field("pixel_ink", due_stamp.ink,
                    out_tdata[2*POS_BITS+2*PEN_BITS +: INK_BITS]);
        check_field("last", due_stamp.fin, out_tlast);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles == QUIET_MAX) begin
      $display("thick_line_stepper_top verification failed");
      $finish;
    end
  end

  initial begin
    int  goal;
    bit  hold_done;
    bit  drain_done;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tuser   = CMD_LOAD;
    in_tdata   = '0;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    pen_x = 0; pen_y = 0; goal_x = 0; goal_y = 0;
    run_x = 0; rise_neg = 0; slope_err = 0;
    back_x = 1'b0; back_y = 1'b0;
    side = 1; line_color = '0; drawing = 1'b0;

    dir_rows.push_back('{CMD_STEP, 0, 0, 0, 0, 0, 32'h0, 1'b0, NO_STAMP});
    dir_rows.push_back('{CMD_LOAD, 0, 0, 0, 0, 1, 32'hFFFF_FFFF, 1'b0, NO_STAMP});
    dir_rows.push_back('{CMD_STEP, 0, 0, 0, 0, 0, 32'h0, 1'b1,
                         mk_stamp(0, 0, 1, 1, 1'b0, 32'hFFFF_FFFF, 1'b1)});
    dir_rows.push_back('{CMD_LOAD, -2048, -2048, -2048, -2048, 15, 32'h0, 1'b0, NO_STAMP});
    dir_rows.push_back('{CMD_STEP, 0, 0, 0, 0, 0, 32'h0, 1'b1,
                         mk_stamp(0, 0, 0, 0, 1'b1, 32'h0, 1'b1)});
    dir_rows.push_back('{CMD_LOAD, 2047, 2047, 2047, 2047, 15, 32'hA5A5_A5A5, 1'b0,
                         NO_STAMP});
    dir_rows.push_back('{CMD_STEP, 0, 0, 0, 0, 0, 32'h0, 1'b1,
                         mk_stamp(0, 0, 0, 0, 1'b1, 32'hA5A5_A5A5, 1'b1)});
    // A zero pen size leaves nothing to draw.
    dir_rows.push_back('{CMD_LOAD, 100, 100, 100, 100, 0, 32'h5A5A_5A5A, 1'b0, NO_STAMP});
    dir_rows.push_back('{CMD_STEP, 0, 0, 0, 0, 0, 32'h0, 1'b1,
                         mk_stamp(0, 0, 0, 0, 1'b1, 32'h5A5A_5A5A, 1'b1)});
    dir_rows.push_back('{CMD_LOAD, 1279, 799, 1279, 799, 15, 32'h1234_5678, 1'b0, NO_STAMP});
    dir_rows.push_back('{CMD_STEP, 0, 0, 0, 0, 0, 32'h0, 1'b1,
                         mk_stamp(1272, 792, 8, 8, 1'b0, 32'h1234_5678, 1'b1)});
    dir_rows.push_back('{CMD_LOAD, 0, 0, 0, 0, 15, 32'h8765_4321, 1'b0, NO_STAMP});
    dir_rows.push_back('{CMD_STEP, 0, 0, 0, 0, 0, 32'h0, 1'b1,
                         mk_stamp(0, 0, 8, 8, 1'b0, 32'h8765_4321, 1'b1)});
    dir_rows.push_back('{CMD_LOAD, 5, 5, 8, 3, 3, 32'h0F0F_0F0F, 1'b0, NO_STAMP});
    repeat (5) dir_rows.push_back('{CMD_STEP, 0, 0, 0, 0, 0, 32'h0, 1'b0, NO_STAMP});
    dir_rows.push_back('{CMD_LOAD, 10, 10, 20, 20, 2, 32'h00FF_00FF, 1'b0, NO_STAMP});
    repeat (2) dir_rows.push_back('{CMD_STEP, 0, 0, 0, 0, 0, 32'h0, 1'b0, NO_STAMP});
    // A new load in the middle of a line replaces it.
    dir_rows.push_back('{CMD_LOAD, 30, 30, 28, 40, 2, 32'hFF00_FF00, 1'b0, NO_STAMP});
    repeat (2) dir_rows.push_back('{CMD_STEP, 0, 0, 0, 0, 0, 32'h0, 1'b0, NO_STAMP});

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) begin
      push_word(dir_rows[i].kind,
                line_word(dir_rows[i].sx, dir_rows[i].sy, dir_rows[i].ex, dir_rows[i].ey,
                          dir_rows[i].pen, dir_rows[i].ink),
                dir_rows[i].typed, dir_rows[i].want);
    end

    goal = dir_rows.size() + RAND_WORDS;
    while (words_sent < goal) begin
      if (!hold_done && words_sent > 600) begin
        // Keep sending at full rate while the receiver holds off.
        send_gap_pct = 0;
        hold_req = 1'b1;
        hold_done = 1'b1;
      end
      if (!drain_done && words_sent > 1000) begin
        settle_input();
        drain_done = 1'b1;
      end
      if (words_sent > goal - 250) begin
        send_gap_pct = 0;
        stall_pct = 0;
      end else if (!hold_req) begin
        case ($urandom_range(0, 3))
          0: send_gap_pct = 0;
          1: send_gap_pct = 5;
          2: send_gap_pct = 20;
          default: send_gap_pct = 40;
        endcase
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 5;
          2: stall_pct = 20;
          default: stall_pct = 40;
        endcase
      end
      if ($urandom_range(0, 99) < 85) draw_line();
      else push_word(cmd_kind_t'($urandom_range(0, 1)), rand_word(), 1'b0, NO_STAMP);
    end

    settle_input();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("thick_line_stepper_top verification clean");
    end else begin
      $display("thick_line_stepper_top verification failed");
    end
    $finish;
  end

endmodule
